// ===== sv/fbee_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbee_pkg
// Shared types and constants of the footswitch bank event engine.
// ----------------------------------------------------------------------------
package fbee_pkg;

  localparam int BANKS    = 8;
  localparam int SWITCHES = 8;

  localparam logic [3:0] GROUP_NONE = 4'd8;
  localparam logic [7:0] PAIR_DOWN  = 8'h30;
  localparam logic [7:0] PAIR_UP    = 8'hC0;

  localparam logic [2:0] CFG_BANK_COUNT = 3'd0;
  localparam logic [2:0] CFG_LONG_TICKS = 3'd1;
  localparam logic [2:0] CFG_START_BANK = 3'd2;
  localparam logic [2:0] CFG_MAP_01     = 3'd3;
  localparam logic [2:0] CFG_MAP_23     = 3'd4;
  localparam logic [2:0] CFG_MAP_45     = 3'd5;
  localparam logic [2:0] CFG_MAP_67     = 3'd6;

  localparam logic [1:0] MODE_SHORT  = 2'd0;
  localparam logic [1:0] MODE_LONG   = 2'd1;
  localparam logic [1:0] MODE_TOGGLE = 2'd2;
  localparam logic [1:0] MODE_GROUP  = 2'd3;

  localparam logic [1:0] KIND_TRIGGER  = 2'd0;
  localparam logic [1:0] KIND_MOM_DOWN = 2'd1;
  localparam logic [1:0] KIND_MOM_UP   = 2'd2;
  localparam logic [1:0] KIND_STATUS   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NAV,
    ST_SCAN,
    ST_EMIT,
    ST_STATUS
  } fbee_state_t;

  typedef struct packed {
    logic load_in;
    logic nav;
    logic sw_step;
    logic emit_evt;
    logic emit_status;
    logic next_sw;
  } fbee_cmd_t;

  typedef struct packed {
    logic evt_pending;
    logic last_sw;
    logic out_free;
  } fbee_stat_t;

endpackage

`default_nettype wire

// ===== sv/fbee_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbee_ctrl
// Tick sequencer: combo step, one switch per scan step, event drain, status.
// ----------------------------------------------------------------------------
module fbee_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  fbee_pkg::fbee_stat_t    stat,
  output fbee_pkg::fbee_cmd_t     cmd
);
  import fbee_pkg::*;

  fbee_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_NAV;
      ST_NAV:    state_nxt = ST_SCAN;
      ST_SCAN:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!stat.evt_pending) begin
          state_nxt = stat.last_sw ? ST_STATUS : ST_SCAN;
        end
      end
      ST_STATUS: if (stat.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_NAV:  cmd.nav = 1'b1;
      ST_SCAN: cmd.sw_step = 1'b1;
      ST_EMIT: begin
        cmd.emit_evt = stat.evt_pending && stat.out_free;
        cmd.next_sw  = !stat.evt_pending && !stat.last_sw;
      end
      ST_STATUS: cmd.emit_status = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/fbee_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbee_datapath
// Configuration, switch state, per-switch classification and output register.
// ----------------------------------------------------------------------------
module fbee_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [63:0]      cfg_wdata,
  input  wire logic [7:0]       in_switch,
  input  fbee_pkg::fbee_cmd_t   cmd,
  output fbee_pkg::fbee_stat_t  stat,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_kind,
  output logic [15:0]           out_data,
  output logic                  out_last
);
  import fbee_pkg::*;

  // configuration
  logic [3:0]  bank_count_r;
  logic [7:0]  long_ticks_r;
  logic [63:0] map_r [4];

  // tick state
  logic [2:0]  cur_bank_r;
  logic [7:0]  prev_r;
  logic [7:0]  hold_r [SWITCHES];
  logic [7:0]  long_done_r;
  logic [3:0]  mom_sel_r;
  logic [7:0]  toggle_r [BANKS];
  logic [3:0]  group_r [BANKS];
  logic        locked_r;
  logic [7:0]  hold_set_r;
  logic [7:0]  used_set_r;
  logic [7:0]  combo_r;
  logic [7:0]  defer_r;
  logic [7:0]  now_r;
  logic [2:0]  idx_r;

  // event buffer, slot 0 leaves first
  logic [1:0]  ev_cnt_r;
  logic [1:0]  ev_kind_r [2];
  logic        ev_useb_r [2];
  logic        ev_mom_r;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [15:0] out_data_r;
  logic        out_last_r;

  // restoring remainder, four compare/subtract steps; v < 16 * c always holds
  function automatic logic [2:0] wrap_mod(input logic [3:0] v, input logic [3:0] c);
    logic [6:0] r;
    r = {3'd0, v};
    for (int k = 3; k >= 0; k--) begin
      if (r >= ({3'd0, c} << k)) r = r - ({3'd0, c} << k);
    end
    return r[2:0];
  endfunction

  logic [3:0] eff_cnt;
  always_comb begin
    if (bank_count_r == 4'd0) eff_cnt = 4'd1;
    else if (bank_count_r > 4'd8) eff_cnt = 4'd8;
    else eff_cnt = bank_count_r;
  end

  logic [63:0] map_word;
  logic [7:0]  tog_b;
  logic [3:0]  grp_b;
  assign map_word = map_r[cur_bank_r[2:1]];
  assign tog_b    = toggle_r[cur_bank_r];
  assign grp_b    = group_r[cur_bank_r];

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // combo detection
  logic       down_pair, up_pair;
  logic [7:0] pair;
  logic [2:0] bank_step;
  assign down_pair = (now_r & PAIR_DOWN) == PAIR_DOWN;
  assign up_pair   = (now_r & PAIR_UP) == PAIR_UP;
  assign pair      = down_pair ? PAIR_DOWN : PAIR_UP;
  assign bank_step = down_pair ? wrap_mod({1'b0, cur_bank_r} + eff_cnt - 4'd1, eff_cnt)
                               : wrap_mod({1'b0, cur_bank_r} + 4'd1, eff_cnt);

  // one switch step
  logic [3:0] nib;
  logic [1:0] mode;
  logic       mom, now_b, was_b, down, up, skip, tog_bit;
  logic [7:0] h_nxt;
  logic       ld_nxt, def_nxt, msel_nxt, flip, grp_wr;
  logic [1:0] n_ev;
  logic [1:0] k0, k1;
  logic       u0, u1;

  always_comb begin
    nib     = map_word[{cur_bank_r[0], idx_r, 2'b00} +: 4];
    mode    = nib[1:0];
    mom     = nib[2];
    now_b   = now_r[idx_r];
    was_b   = prev_r[idx_r];
    down    = now_b && !was_b;
    up      = !now_b && was_b;
    skip    = (locked_r && !hold_set_r[idx_r]) || used_set_r[idx_r] || combo_r[idx_r];
    tog_bit = tog_b[idx_r];
    h_nxt   = hold_r[idx_r];
    ld_nxt  = long_done_r[idx_r];
    def_nxt = defer_r[idx_r];
    msel_nxt = mom_sel_r[idx_r[1:0]];
    flip    = 1'b0;
    grp_wr  = 1'b0;
    n_ev    = 2'd0;
    k0 = KIND_TRIGGER; k1 = KIND_TRIGGER; u0 = 1'b0; u1 = 1'b0;
    if (skip) begin
      h_nxt  = 8'd0;
      ld_nxt = 1'b0;
    end else if (idx_r[2]) begin
      if (down) begin
        def_nxt = 1'b1;
        h_nxt   = 8'd0;
        ld_nxt  = 1'b0;
      end else if (now_b && defer_r[idx_r]) begin
        h_nxt = (h_nxt < long_ticks_r) ? h_nxt + 8'd1 : long_ticks_r;
      end else if (up && defer_r[idx_r]) begin
        def_nxt = 1'b0;
        n_ev = 2'd1;
        k0   = KIND_TRIGGER;
        unique case (mode)
          MODE_GROUP:  grp_wr = 1'b1;
          MODE_TOGGLE: begin
            u0   = tog_bit;
            flip = 1'b1;
          end
          MODE_LONG:   u0 = h_nxt >= long_ticks_r;
          MODE_SHORT:  u0 = 1'b0;
        endcase
        h_nxt  = 8'd0;
        ld_nxt = 1'b0;
      end
    end else begin
      if (down) begin
        h_nxt  = 8'd0;
        ld_nxt = 1'b0;
        if (mom) begin
          k0 = KIND_MOM_DOWN;
          u0 = (mode == MODE_TOGGLE) && tog_bit;
          if (mode == MODE_TOGGLE) msel_nxt = tog_bit;
          n_ev = 2'd1;
        end
        if (mode == MODE_GROUP || mode == MODE_TOGGLE) begin
          grp_wr = mode == MODE_GROUP;
          flip   = mode == MODE_TOGGLE;
          if (n_ev == 2'd0) begin
            k0 = KIND_TRIGGER;
            u0 = (mode == MODE_TOGGLE) && tog_bit;
          end else begin
            k1 = KIND_TRIGGER;
            u1 = (mode == MODE_TOGGLE) && tog_bit;
          end
          n_ev = n_ev + 2'd1;
        end
      end
      if (now_b) begin
        h_nxt = (h_nxt < long_ticks_r) ? h_nxt + 8'd1 : long_ticks_r;
        if (mode == MODE_LONG && !ld_nxt && h_nxt >= long_ticks_r) begin
          if (n_ev == 2'd0) begin
            k0 = KIND_TRIGGER; u0 = 1'b1;
          end else begin
            k1 = KIND_TRIGGER; u1 = 1'b1;
          end
          n_ev   = n_ev + 2'd1;
          ld_nxt = 1'b1;
        end
      end
      if (up) begin
        if (mom) begin
          k0   = KIND_MOM_UP;
          u0   = (mode == MODE_TOGGLE) && mom_sel_r[idx_r[1:0]];
          n_ev = 2'd1;
        end
        if (mode == MODE_SHORT ||
            (mode == MODE_LONG && !ld_nxt && h_nxt < long_ticks_r)) begin
          if (n_ev == 2'd0) begin
            k0 = KIND_TRIGGER; u0 = 1'b0;
          end else begin
            k1 = KIND_TRIGGER; u1 = 1'b0;
          end
          n_ev = n_ev + 2'd1;
        end
        h_nxt  = 8'd0;
        ld_nxt = 1'b0;
      end
    end
  end

  // LED mask from the state after the scan
  logic [7:0] led;
  always_comb begin
    logic [3:0] m;
    logic       on;
    led = '0;
    for (int i = 0; i < SWITCHES; i++) begin
      m = map_word[{cur_bank_r[0], 3'(i), 2'b00} +: 4];
      if (m[1:0] == MODE_GROUP) on = grp_b == 4'(i);
      else if (m[1:0] == MODE_TOGGLE) on = m[3] ? toggle_r[cur_bank_r][i]
                                                : !toggle_r[cur_bank_r][i];
      else on = 1'b1;
      led[i] = on && !now_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_count_r <= 4'd8;
      long_ticks_r <= 8'd40;
      for (int b = 0; b < 4; b++) map_r[b] <= '0;
      cur_bank_r  <= 3'd0;
      prev_r      <= '0;
      for (int i = 0; i < SWITCHES; i++) hold_r[i] <= '0;
      long_done_r <= '0;
      mom_sel_r   <= '0;
      for (int b = 0; b < BANKS; b++) begin
        toggle_r[b] <= '0;
        group_r[b]  <= GROUP_NONE;
      end
      locked_r    <= 1'b0;
      hold_set_r  <= '0;
      used_set_r  <= '0;
      combo_r     <= '0;
      defer_r     <= '0;
      idx_r       <= '0;
      ev_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BANK_COUNT: bank_count_r <= cfg_wdata[3:0];
          CFG_LONG_TICKS: long_ticks_r <= cfg_wdata[7:0];
          CFG_START_BANK: cur_bank_r <= wrap_mod({1'b0, cfg_wdata[2:0]}, eff_cnt);
          CFG_MAP_01, CFG_MAP_23, CFG_MAP_45, CFG_MAP_67:
            map_r[2'(cfg_index - CFG_MAP_01)] <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load_in) idx_r <= '0;
      if (cmd.next_sw) idx_r <= idx_r + 3'd1;
      if (cmd.nav) begin
        if (locked_r) begin
          if ((now_r & hold_set_r) == 8'd0) begin
            locked_r   <= 1'b0;
            hold_set_r <= '0;
            used_set_r <= '0;
            combo_r    <= '0;
          end
        end else if (down_pair || up_pair) begin
          cur_bank_r <= bank_step;
          combo_r    <= pair;
          locked_r   <= 1'b1;
          hold_set_r <= pair;
          used_set_r <= pair;
          defer_r    <= defer_r & ~pair;
        end
      end
      if (cmd.sw_step) begin
        hold_r[idx_r]      <= h_nxt;
        long_done_r[idx_r] <= ld_nxt;
        defer_r[idx_r]     <= def_nxt;
        if (!idx_r[2]) mom_sel_r[idx_r[1:0]] <= msel_nxt;
        if (flip) toggle_r[cur_bank_r][idx_r] <= !tog_bit;
        if (grp_wr) group_r[cur_bank_r] <= {1'b0, idx_r};
        ev_cnt_r <= n_ev;
      end
      if (cmd.emit_evt) ev_cnt_r <= ev_cnt_r - 2'd1;
      if (cmd.emit_status) prev_r <= now_r;
      if (cmd.emit_evt || cmd.emit_status) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) now_r <= in_switch;
    if (cmd.sw_step) begin
      ev_kind_r[0] <= k0; ev_useb_r[0] <= u0;
      ev_kind_r[1] <= k1; ev_useb_r[1] <= u1;
      ev_mom_r     <= mom;
    end
    if (cmd.emit_evt) begin
      ev_kind_r[0] <= ev_kind_r[1];
      ev_useb_r[0] <= ev_useb_r[1];
      out_kind_r   <= ev_kind_r[0];
      out_data_r   <= {8'd0, cur_bank_r, ev_mom_r, ev_useb_r[0], idx_r};
      out_last_r   <= 1'b0;
    end else if (cmd.emit_status) begin
      out_kind_r <= KIND_STATUS;
      out_data_r <= {led, cur_bank_r, 5'd0};
      out_last_r <= 1'b1;
    end
  end

  assign stat.evt_pending = ev_cnt_r != 2'd0;
  assign stat.last_sw     = idx_r == 3'(SWITCHES - 1);
  assign stat.out_free    = out_free;

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== sv/footswitch_bank_event_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// footswitch_bank_event_engine
// Classifies eight footswitches per scan tick and emits action events.
// ----------------------------------------------------------------------------
// Usage: each transfer on the in_ channel is one scan tick (bit i = switch i
// pressed). The block answers with zero or more action events (kind trigger,
// momentary down or momentary up) in switch order, then one status item
// (tuser = status, tlast = 1) carrying the LED mask and the bank.
// Sequence: the tick is accepted, the bank-step check runs, then each switch
// gets a classify step and a drain step that sends its events one by one,
// then the status item is sent. The sequencer handles one tick at a time;
// in_tready is high only between ticks.
// The output register lets the next tick be accepted while the status item
// still waits. When the receiver stalls, the sequencer holds on the pending
// event and nothing is dropped. Reset (rst_n low, synchronous) restores the
// register defaults and clears all switch state; bank 0 is loaded.
// cfg_ writes are taken at once and are meant for when no tick is in flight.
// ----------------------------------------------------------------------------
module footswitch_bank_event_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] switch_pressed
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [2:0] button, [3] use_list_b, [4] momentary,
                                       // [7:5] bank_now, [15:8] led_mask
  output logic [1:0]       out_tuser,  // [1:0] event_kind
  output logic             out_tlast   // last_of_tick
);
  import fbee_pkg::*;

  fbee_cmd_t  cmd;
  fbee_stat_t stat;

  fbee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fbee_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_switch (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== sv/fbee_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbee_checker
// Port-level checks of the footswitch bank event engine.
// ----------------------------------------------------------------------------
module fbee_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);
  import fbee_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("new tick accepted while one is in flight");

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == KIND_STATUS)))
    else $error("tlast and status kind disagree");

  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[4:0] == 5'd0)
    else $error("status item carries event fields");

  a_event_no_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[15:8] == 8'd0)
    else $error("event item carries an LED mask");

endmodule

bind footswitch_bank_event_engine fbee_checker u_fbee_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
